/* rtl/core/rlkd_pkg.sv */
package rlkd_pkg;

    // Fixed field widths
    localparam int THR_W    = 10;
    localparam int TOL_W    = 8;
    localparam int CNT_W    = 8;
    localparam int EVENT_W  = 3;
    localparam int KEY_W    = 3;
    localparam int DRIVE_W  = 4;
    localparam int CENTER_W = 10;

    // Configuration register indexes (byte address = 4 * index)
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_THR_CH0  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THR_CH1  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd3;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_IDLE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_LATCH   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_MATCH   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_UNKNOWN = 3'd3;
    localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd4;

    // Key numbers with a side action
    localparam logic [KEY_W-1:0] KEY_NONE       = 3'd0;
    localparam logic [KEY_W-1:0] KEY_AUX_TOGGLE = 3'd1;
    localparam logic [KEY_W-1:0] KEY_LAST_DRIVE = 3'd4;

    // Ladder key centres, in priority order
    localparam int N_KEYS_CH0 = 4;
    localparam int N_KEYS_CH1 = 7;
    localparam logic [CENTER_W-1:0] CENTERS_CH0 [0:N_KEYS_CH0-1] =
        '{10'd604, 10'd440, 10'd312, 10'd231};
    localparam logic [CENTER_W-1:0] CENTERS_CH1 [0:N_KEYS_CH1-1] =
        '{10'd543, 10'd352, 10'd271, 10'd240, 10'd184, 10'd206, 10'd224};

    // Settings seen by the datapath
    typedef struct packed {
        logic [THR_W-1:0] thr_ch0;
        logic [THR_W-1:0] thr_ch1;
        logic [TOL_W-1:0] tolerance;
        logic [CNT_W-1:0] debounce_limit;
    } cfg_t;

endpackage

/* rtl/core/resistor_ladder_key_decoder.sv */
// A word accepted at s_tdata passes the input register, then the result register,
// before its result shows on m_tdata.
// Throughput: one word per cycle; the window compare on the latched level is the
// longest path. A held result stalls input only when the input register is also full.
// Reset (rst_n, asynchronous, active low) clears channel state, the aux and drive
// outputs and the valid flags, and loads the register defaults.
module resistor_ladder_key_decoder #(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // Sample stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata, // sample
    input  logic [0:0]                           s_tuser,  // channel
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [15:0]                          m_tdata   // event_res, key_index,
                                                           // aux_enable, line_drive
);
    import rlkd_pkg::*;

    localparam int OUT_W = EVENT_W + KEY_W + 1 + DRIVE_W;

    cfg_t                   cfg;
    logic                   in_valid_reg;
    logic                   channel_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   take;
    logic [EVENT_W-1:0]     event_res;
    logic [KEY_W-1:0]       key_index;
    logic                   aux_enable;
    logic [DRIVE_W-1:0]     line_drive;

    rlkd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            channel_reg <= s_tuser[0];
            sample_reg  <= s_tdata[SAMPLE_BITS-1:0];
        end
    end

    rlkd_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid_reg),
        .channel    (channel_reg),
        .sample     (sample_reg),
        .take       (take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .event_res  (event_res),
        .key_index  (key_index),
        .aux_enable (aux_enable),
        .line_drive (line_drive)
    );

    // Result word, lowest field first
    assign m_tdata = 16'({line_drive, aux_enable, key_index, event_res});

    // Word counts through the two registers stay within capacity
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while both stages full");

    a_out_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:OUT_W] == '0))
        else $error("pad bits of the result word set");

    a_take_source: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> in_valid_reg)
        else $error("word taken from an empty input register");

endmodule

/* rtl/core/rlkd_regs.sv */
module rlkd_regs
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output rlkd_pkg::cfg_t            cfg
);
    import rlkd_pkg::*;

    logic [THR_W-1:0]     thr_ch0_reg;
    logic [THR_W-1:0]     thr_ch1_reg;
    logic [TOL_W-1:0]     tolerance_reg;
    logic [CNT_W-1:0]     debounce_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_ch0_reg   <= THR_W'(220);
            thr_ch1_reg   <= THR_W'(100);
            tolerance_reg <= TOL_W'(10);
            debounce_reg  <= CNT_W'(10);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_THR_CH0:   thr_ch0_reg   <= pwdata[THR_W-1:0];
                REG_THR_CH1:   thr_ch1_reg   <= pwdata[THR_W-1:0];
                REG_TOLERANCE: tolerance_reg <= pwdata[TOL_W-1:0];
                REG_DEBOUNCE:  debounce_reg  <= pwdata[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_THR_CH0:   prdata = 32'(thr_ch0_reg);
            REG_THR_CH1:   prdata = 32'(thr_ch1_reg);
            REG_TOLERANCE: prdata = 32'(tolerance_reg);
            REG_DEBOUNCE:  prdata = 32'(debounce_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.thr_ch0        = thr_ch0_reg;
    assign cfg.thr_ch1        = thr_ch1_reg;
    assign cfg.tolerance      = tolerance_reg;
    assign cfg.debounce_limit = debounce_reg;

endmodule

/* rtl/core/rlkd_match.sv */
module rlkd_match #(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                        channel,
    input  logic [SAMPLE_BITS-1:0]      level,
    input  logic [rlkd_pkg::TOL_W-1:0]  tolerance,
    output logic [rlkd_pkg::KEY_W-1:0]  key
);
    import rlkd_pkg::*;

    // Compare width holds either operand plus a spare bit
    localparam int CW = ((SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W) + 1;

    logic [CW-1:0]         lvl_ext;
    logic [CW-1:0]         tol_ext;
    logic [N_KEYS_CH0-1:0] hit_ch0;
    logic [N_KEYS_CH1-1:0] hit_ch1;

    assign lvl_ext = CW'(level);
    assign tol_ext = CW'(tolerance);

    // Window test against every centre in parallel
    always_comb
    begin
        logic [CW-1:0] c;
        for (int i = 0; i < N_KEYS_CH0; i++)
        begin
            c = CW'(CENTERS_CH0[i]);
            hit_ch0[i] = ((lvl_ext >= c) ? (lvl_ext - c) : (c - lvl_ext)) <= tol_ext;
        end
        for (int j = 0; j < N_KEYS_CH1; j++)
        begin
            c = CW'(CENTERS_CH1[j]);
            hit_ch1[j] = ((lvl_ext >= c) ? (lvl_ext - c) : (c - lvl_ext)) <= tol_ext;
        end
    end

    // First hit in table order wins
    always_comb
    begin
        key = KEY_NONE;
        if (channel)
        begin
            for (int j = N_KEYS_CH1 - 1; j >= 0; j--)
                if (hit_ch1[j])
                    key = KEY_W'(j + 1);
        end
        else
        begin
            for (int i = N_KEYS_CH0 - 1; i >= 0; i--)
                if (hit_ch0[i])
                    key = KEY_W'(i + 1);
        end
    end

endmodule

/* rtl/core/rlkd_core.sv */
module rlkd_core #(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rlkd_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    input  logic                          channel,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          take,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rlkd_pkg::EVENT_W-1:0]  event_res,
    output logic [rlkd_pkg::KEY_W-1:0]    key_index,
    output logic                          aux_enable,
    output logic [rlkd_pkg::DRIVE_W-1:0]  line_drive
);
    import rlkd_pkg::*;

    localparam int CMP_W = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;

    // Per-channel state
    logic [1:0]             pressed_reg;
    logic [CNT_W-1:0]       count_reg [2];
    logic [SAMPLE_BITS-1:0] latched_reg [2];
    logic                   aux_reg;
    logic [DRIVE_W-1:0]     drive_reg;

    logic [1:0]             pressed_next;
    logic [CNT_W-1:0]       count_next [2];
    logic [SAMPLE_BITS-1:0] latched_next [2];
    logic                   aux_next;
    logic [DRIVE_W-1:0]     drive_next;

    // Result register
    logic                   out_valid_reg;
    logic [EVENT_W-1:0]     event_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [EVENT_W-1:0]     event_next;
    logic [KEY_W-1:0]       key_next;

    logic [THR_W-1:0]       thr;
    logic                   above;
    logic [KEY_W-1:0]       match_key;

    assign take = in_valid && (!out_valid_reg || out_ready);
    assign thr  = channel ? cfg.thr_ch1 : cfg.thr_ch0;
    assign above = CMP_W'(sample) > CMP_W'(thr);

    rlkd_match #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_match (
        .channel   (channel),
        .level     (latched_reg[channel]),
        .tolerance (cfg.tolerance),
        .key       (match_key)
    );

    // Next state for the word in the input register
    always_comb
    begin
        pressed_next = pressed_reg;
        count_next   = count_reg;
        latched_next = latched_reg;
        aux_next     = aux_reg;
        drive_next   = drive_reg;
        event_next   = EV_IDLE;
        key_next     = KEY_NONE;
        if (above)
        begin
            if (pressed_reg[channel])
            begin
                key_next = match_key;
                if (match_key == KEY_NONE)
                    event_next = EV_UNKNOWN;
                else
                begin
                    event_next = EV_MATCH;
                    if (!channel)
                    begin
                        if (match_key == KEY_AUX_TOGGLE)
                        begin
                            aux_next        = !aux_reg;
                            latched_next[0] = '0;
                        end
                    end
                    else if (match_key <= KEY_LAST_DRIVE)
                        drive_next = drive_reg |
                            (DRIVE_W'(1) << 2'(match_key - KEY_AUX_TOGGLE));
                end
            end
            else if (count_reg[channel] >= cfg.debounce_limit)
            begin
                pressed_next[channel] = 1'b1;
                latched_next[channel] = sample;
                count_next[channel]   = '0;
                event_next            = EV_LATCH;
            end
            else
                count_next[channel] = count_reg[channel] + CNT_W'(1);
        end
        else if (pressed_reg[channel])
        begin
            pressed_next[channel] = 1'b0;
            latched_next[channel] = '0;
            if (channel)
                drive_next = '0;
            event_next = EV_RELEASE;
        end
    end

    // State and result update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg    <= '0;
            count_reg[0]   <= '0;
            count_reg[1]   <= '0;
            latched_reg[0] <= '0;
            latched_reg[1] <= '0;
            aux_reg        <= 1'b0;
            drive_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pressed_reg   <= pressed_next;
                count_reg     <= count_next;
                latched_reg   <= latched_next;
                aux_reg       <= aux_next;
                drive_reg     <= drive_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            event_reg <= event_next;
            key_reg   <= key_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = event_reg;
    assign key_index  = key_reg;
    assign aux_enable = aux_reg;
    assign line_drive = drive_reg;

    // A key number goes out with a match and only then
    a_key_with_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((event_reg == EV_MATCH) == (key_reg != KEY_NONE)))
        else $error("key index and match event disagree");

    // Drive, aux and pressed state move only when a word is taken
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> ($stable(drive_reg) && $stable(aux_reg) && $stable(pressed_reg)))
        else $error("state changed without a word");

    // Channel 1 release drops every drive bit
    a_release_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (take && channel && event_next == EV_RELEASE) |=> (drive_reg == '0))
        else $error("drive bits survived a release");

    // Latching always reports a pressed channel
    a_latch_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (take && event_next == EV_LATCH) |=> (pressed_reg[$past(channel)]))
        else $error("latched without pressed flag");

endmodule
